@@ rtl/ghru_pkg.sv @@
package ghru_pkg;

  localparam int N_RESTART = 64;
  localparam int IDX_W     = $clog2(N_RESTART);
  localparam int CNT_W     = $clog2(N_RESTART + 1);
  localparam int ENTRY_W   = 7;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSTART = 2'd1,
    ST_OVER    = 2'd2,
    ST_ZERO    = 2'd3
  } status_e;

  localparam logic OP_START = 1'b0;

  typedef enum logic [1:0] {
    K_START,
    K_ELEM,
    K_LAST
  } kind_e;

  typedef struct packed {
    logic               op;
    logic signed [31:0] value;
    logic               last;
  } item_t;

  typedef struct packed {
    logic signed [31:0]   r_entry;
    logic [ENTRY_W-1:0]   entry_index;
    logic signed [31:0]   beta_out;
    logic [30:0]          residual;
    logic                 column_done;
    logic [1:0]           status;
  } result_t;

  // classified item handed from front to back
  typedef struct packed {
    logic               vld;
    kind_e              kind;
    logic signed [31:0] value;
  } work_t;

  // round half up at bit 30, then saturate to 32 bits
  function automatic logic signed [31:0] rnd_sat(input logic signed [65:0] acc);
    logic signed [65:0] w;
    logic signed [65:0] sh;
    w  = acc + 66'sd536870912;
    sh = w >>> 30;
    if (sh > 66'sd2147483647) begin
      rnd_sat = 32'sh7fffffff;
    end else if (sh < -66'sd2147483648) begin
      rnd_sat = 32'sh80000000;
    end else begin
      rnd_sat = sh[31:0];
    end
  endfunction

  function automatic logic [30:0] abs_sat31(input logic signed [31:0] v);
    logic [31:0] n;
    n = -v;
    if (v == 32'sh80000000) begin
      abs_sat31 = '1;
    end else if (v[31]) begin
      abs_sat31 = n[30:0];
    end else begin
      abs_sat31 = v[30:0];
    end
  endfunction

endpackage

@@ rtl/ghru_front.sv @@
module ghru_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  ghru_pkg::item_t item_i,
  output ghru_pkg::work_t work_o,
  input  logic            take_i
);

  ghru_pkg::work_t ent_q [2];
  logic            wp_q, rp_q;
  logic [1:0]      cnt_q;
  ghru_pkg::kind_e kind;
  logic            wr, rd;

  assign full = (cnt_q == 2'd2);
  assign wr   = push && !full;
  assign rd   = take_i && (cnt_q != 2'd0);

  always_comb begin
    if (item_i.op == ghru_pkg::OP_START) begin
      kind = ghru_pkg::K_START;
    end else if (item_i.last) begin
      kind = ghru_pkg::K_LAST;
    end else begin
      kind = ghru_pkg::K_ELEM;
    end
  end

  always_comb begin
    work_o     = ent_q[rp_q];
    work_o.vld = (cnt_q != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) begin
        wp_q <= !wp_q;
      end
      if (rd) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      ent_q[wp_q] <= '{vld: 1'b1, kind: kind, value: item_i.value};
    end
  end

endmodule

@@ rtl/ghru_back.sv @@
module ghru_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ghru_pkg::work_t   work_i,
  output logic              take_o,
  output logic              res_vld_o,
  output ghru_pkg::result_t res_o,
  input  logic              res_rdy_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_MAC, S_SQ, S_SQRT, S_RND, S_DIV, S_POST, S_OUT
  } state_e;

  state_e                       state_q;
  logic [1:0]                   ms_q;
  logic                         started_q;
  logic [ghru_pkg::CNT_W-1:0]   k_q, e_q;
  logic signed [31:0]           carry_q, beta_q, val_q, c_q, s_q, r_q, bout_q;
  logic signed [31:0]           cm_q, sm_q;
  logic signed [65:0]           acc_q;
  logic [63:0]                  v_q, rt_q, bit_q, na_q, ns_q;
  logic [5:0]                   it_q;
  logic [32:0]                  t_q;
  logic [33:0]                  rema_q, rems_q;
  logic [31:0]                  qa_q, qs_q;
  logic [1:0]                   st_q;
  ghru_pkg::result_t            res_q;

  logic signed [31:0] cos_mem [ghru_pkg::N_RESTART];
  logic signed [31:0] sin_mem [ghru_pkg::N_RESTART];

  logic                         rd_en, wr_en;
  logic [ghru_pkg::IDX_W-1:0]   rd_idx;
  logic                         elem_go;

  // shared multiply-accumulate
  logic signed [32:0] op_a, op_b;
  logic               clr;
  logic signed [65:0] prod, mac;
  logic signed [31:0] rs;

  always_comb begin
    op_a = '0;
    op_b = '0;
    clr  = 1'b1;
    case (state_q)
      S_MAC: begin
        case (ms_q)
          2'd0: begin op_a = {carry_q[31], carry_q}; op_b = {cm_q[31], cm_q}; end
          2'd1: begin op_a = {val_q[31], val_q}; op_b = {sm_q[31], sm_q}; clr = 1'b0; end
          2'd2: begin op_a = {carry_q[31], carry_q}; op_b = -{sm_q[31], sm_q}; end
          default: begin
            op_a = {val_q[31], val_q}; op_b = {cm_q[31], cm_q}; clr = 1'b0;
          end
        endcase
      end
      S_SQ: begin
        if (ms_q == 2'd0) begin
          op_a = {carry_q[31], carry_q}; op_b = {carry_q[31], carry_q};
        end else begin
          op_a = {val_q[31], val_q}; op_b = {val_q[31], val_q}; clr = 1'b0;
        end
      end
      S_POST: begin
        case (ms_q)
          2'd0: begin op_a = {c_q[31], c_q}; op_b = {carry_q[31], carry_q}; end
          2'd1: begin op_a = {s_q[31], s_q}; op_b = {val_q[31], val_q}; clr = 1'b0; end
          2'd2: begin op_a = {c_q[31], c_q}; op_b = {beta_q[31], beta_q}; end
          default: begin op_a = -{s_q[31], s_q}; op_b = {beta_q[31], beta_q}; end
        endcase
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  assign prod = op_a * op_b;
  assign mac  = (clr ? 66'sd0 : acc_q) + prod;
  assign rs   = ghru_pkg::rnd_sat(mac);

  // square root step
  logic [63:0] trial;
  logic        sq_ge;
  assign trial = rt_q + bit_q;
  assign sq_ge = (v_q >= trial);

  // rounded root and dividends
  logic [32:0] t_n;
  logic [31:0] ma, mb;
  assign t_n = (v_q > rt_q) ? 33'(rt_q + 64'd1) : rt_q[32:0];
  assign ma  = carry_q[31] ? 32'(-carry_q) : carry_q;
  assign mb  = val_q[31] ? 32'(-val_q) : val_q;

  // long division step, two lanes sharing the divisor
  logic [33:0] rema_sh, rems_sh;
  logic        ga, gs;
  logic [31:0] qa_n, qs_n;
  assign rema_sh = {rema_q[32:0], na_q[63]};
  assign rems_sh = {rems_q[32:0], ns_q[63]};
  assign ga      = (rema_sh >= {1'b0, t_q});
  assign gs      = (rems_sh >= {1'b0, t_q});
  assign qa_n    = {qa_q[30:0], ga};
  assign qs_n    = {qs_q[30:0], gs};

  assign take_o    = (state_q == S_IDLE);
  assign res_vld_o = (state_q == S_OUT);
  assign res_o     = res_q;

  assign elem_go = work_i.vld && (state_q == S_IDLE) && (work_i.kind == ghru_pkg::K_ELEM)
                   && started_q && (k_q < ghru_pkg::CNT_W'(ghru_pkg::N_RESTART))
                   && (e_q != '0) && (e_q <= k_q);
  assign rd_en   = elem_go;
  assign rd_idx  = ghru_pkg::IDX_W'(e_q - 1'b1);
  assign wr_en   = (state_q == S_POST) && (ms_q == 2'd3);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cos_mem[k_q[ghru_pkg::IDX_W-1:0]] <= c_q;
      sin_mem[k_q[ghru_pkg::IDX_W-1:0]] <= s_q;
    end
    if (rd_en) begin
      cm_q <= cos_mem[rd_idx];
      sm_q <= sin_mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ms_q      <= 2'd0;
      started_q <= 1'b0;
      k_q       <= '0;
      e_q       <= '0;
      carry_q   <= '0;
      beta_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          ms_q <= 2'd0;
          if (work_i.vld) begin
            if (work_i.kind == ghru_pkg::K_START) begin
              k_q     <= '0;
              e_q     <= '0;
              carry_q <= '0;
              state_q <= S_OUT;
              if (work_i.value == 32'sd0) begin
                started_q <= 1'b0;
                beta_q    <= '0;
                res_q     <= '{'0, '0, '0, '0, 1'b0, ghru_pkg::ST_ZERO};
              end else begin
                started_q <= 1'b1;
                beta_q    <= work_i.value;
                res_q     <= '{'0, '0, work_i.value, ghru_pkg::abs_sat31(work_i.value),
                               1'b0, ghru_pkg::ST_OK};
              end
            end else if (!started_q) begin
              res_q   <= '{'0, '0, '0, '0, 1'b0, ghru_pkg::ST_NOSTART};
              state_q <= S_OUT;
            end else if (k_q >= ghru_pkg::CNT_W'(ghru_pkg::N_RESTART)) begin
              res_q   <= '{'0, '0, '0, '0, 1'b0, ghru_pkg::ST_OVER};
              state_q <= S_OUT;
            end else if (work_i.kind == ghru_pkg::K_LAST) begin
              val_q   <= work_i.value;
              state_q <= S_SQ;
            end else if (e_q == '0) begin
              carry_q <= work_i.value;
              e_q     <= ghru_pkg::CNT_W'(1);
            end else if (elem_go) begin
              val_q   <= work_i.value;
              state_q <= S_MAC;
            end
          end
        end
        S_MAC: begin
          acc_q <= mac;
          ms_q  <= ms_q + 2'd1;
          if (ms_q == 2'd1) begin
            r_q <= rs;
          end
          if (ms_q == 2'd3) begin
            carry_q <= rs;
            e_q     <= e_q + 1'b1;
            res_q   <= '{r_q, ghru_pkg::ENTRY_W'(e_q - 1'b1), '0, '0, 1'b0, ghru_pkg::ST_OK};
            state_q <= S_OUT;
          end
        end
        S_SQ: begin
          acc_q <= mac;
          if (ms_q == 2'd1) begin
            v_q <= mac[63:0];
            if (mac == 66'sd0) begin
              c_q     <= 32'sd1073741824;
              s_q     <= '0;
              st_q    <= ghru_pkg::ST_ZERO;
              ms_q    <= 2'd0;
              state_q <= S_POST;
            end else begin
              st_q    <= ghru_pkg::ST_OK;
              rt_q    <= '0;
              bit_q   <= 64'd1 << 62;
              it_q    <= '0;
              state_q <= S_SQRT;
            end
          end else begin
            ms_q <= ms_q + 2'd1;
          end
        end
        S_SQRT: begin
          if (sq_ge) begin
            v_q  <= v_q - trial;
            rt_q <= (rt_q >> 1) + bit_q;
          end else begin
            rt_q <= rt_q >> 1;
          end
          bit_q <= bit_q >> 2;
          it_q  <= it_q + 6'd1;
          if (it_q == 6'd31) begin
            state_q <= S_RND;
          end
        end
        S_RND: begin
          t_q     <= t_n;
          na_q    <= ({32'd0, ma} << 30) + {32'd0, t_n[32:1]};
          ns_q    <= ({32'd0, mb} << 30) + {32'd0, t_n[32:1]};
          rema_q  <= '0;
          rems_q  <= '0;
          it_q    <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          rema_q <= ga ? rema_sh - {1'b0, t_q} : rema_sh;
          rems_q <= gs ? rems_sh - {1'b0, t_q} : rems_sh;
          na_q   <= na_q << 1;
          ns_q   <= ns_q << 1;
          qa_q   <= qa_n;
          qs_q   <= qs_n;
          it_q   <= it_q + 6'd1;
          if (it_q == 6'd63) begin
            c_q     <= carry_q[31] ? -qa_n : qa_n;
            s_q     <= val_q[31] ? -qs_n : qs_n;
            ms_q    <= 2'd0;
            state_q <= S_POST;
          end
        end
        S_POST: begin
          acc_q <= mac;
          ms_q  <= ms_q + 2'd1;
          if (ms_q == 2'd1) begin
            r_q <= rs;
          end
          if (ms_q == 2'd2) begin
            bout_q <= rs;
          end
          if (ms_q == 2'd3) begin
            beta_q  <= rs;
            k_q     <= k_q + 1'b1;
            e_q     <= '0;
            carry_q <= '0;
            res_q   <= '{r_q, ghru_pkg::ENTRY_W'(k_q), bout_q, ghru_pkg::abs_sat31(rs),
                         1'b1, st_q};
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_rdy_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/givens_hessenberg_residual_update_unit.sv @@
// A start or status item goes straight to a result; a rotated element runs the rotation
// multiply-accumulate; a column close runs squares, root, rounding, divide, then the
// post-multiply (a zero pair skips root and divide). The back end handles one item at a
// time and waits until its result is handed on; a carry load or dropped entry yields none.
// Input queue holds 2 items, output register 1 result. Reset: rst_ni async active low
// clears queues, counters, carry, beta and started; rotation tables are not cleared.
module givens_hessenberg_residual_update_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  ghru_pkg::item_t   item_i,
  output logic              empty,
  input  logic              pop,
  output ghru_pkg::result_t result_o
);

  ghru_pkg::work_t   work;
  logic              take;
  logic              res_vld, res_rdy;
  ghru_pkg::result_t res;

  logic              ovld_q;
  ghru_pkg::result_t out_q;

  // front: accepts transfers and tags them start / element / last
  ghru_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .item_i (item_i),
    .work_o (work),
    .take_i (take)
  );

  // back: rotations, root, divide, table store
  ghru_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .work_i    (work),
    .take_o    (take),
    .res_vld_o (res_vld),
    .res_o     (res),
    .res_rdy_i (res_rdy)
  );

  // output register: back end may hand over when empty or being popped
  assign res_rdy  = !ovld_q || pop;
  assign empty    = !ovld_q;
  assign result_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (res_rdy) begin
      ovld_q <= res_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_rdy && res_vld) begin
      out_q <= res;
    end
  end

endmodule

@@ rtl/ghru_checker.sv @@
module ghru_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              empty,
  input logic              pop,
  input ghru_pkg::result_t result_o
);

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("result changed while waiting");

  // column close only on ok or zero pair
  a_done_st: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.column_done) |->
      (result_o.status == ghru_pkg::ST_OK || result_o.status == ghru_pkg::ST_ZERO))
    else $error("column close with bad status");

  // error results carry zero payload
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !result_o.column_done && result_o.status != ghru_pkg::ST_OK) |->
      (result_o.r_entry == 32'sd0 && result_o.beta_out == 32'sd0 &&
       result_o.residual == 31'd0))
    else $error("error result with payload");

  // row index stays inside the restart window
  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (result_o.entry_index < ghru_pkg::ENTRY_W'(ghru_pkg::N_RESTART)))
    else $error("row index out of range");

endmodule

bind givens_hessenberg_residual_update_unit ghru_checker u_ghru_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);
